[hdl/rve_pkg.sv]
package rve_pkg;

  // Number of CORDIC micro-rotations.
  localparam int TRIG_ITERATIONS = 28;

  // Quotient bits produced by each axis divider lane (Q1.30 result, unit magnitude at most).
  localparam int DIV_STEPS = 31;

  // Both the divider lanes and the CORDIC sit in one core section of this many stages.
  localparam int CORE_LAT = (TRIG_ITERATIONS > DIV_STEPS) ? TRIG_ITERATIONS : DIV_STEPS;

  // Stage counts of the other sections.
  localparam int FRONT_LAT  = 2;
  localparam int SQRT_LAT   = 32;
  localparam int REDUCE_LAT = 2;
  localparam int MERGE_LAT  = 3;
  localparam int PIPE_LAT   = FRONT_LAT + SQRT_LAT + REDUCE_LAT + CORE_LAT + MERGE_LAT;

  // Working width of the CORDIC and angle datapath.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [CW-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [CW-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [CW-1:0] TWO_PI_Q28  = 34'sd1686629714;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Unsigned forms of one and two full turns, used on the angle before folding.
  localparam logic [32:0] TURN_U     = 33'd1686629714;
  localparam logic [32:0] TWO_TURN_U = 33'd3373259428;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } mat_t;

  // Information that travels alongside the core section.
  typedef struct packed {
    logic low_angle;
    logic neg_cos;
    vec_t psi;
  } side_t;

  // Arctangent of 2^-i in Q3.28.
  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0: v = 34'sd210828714;
      1: v = 34'sd124459457;
      2: v = 34'sd65760959;
      3: v = 34'sd33381290;
      4: v = 34'sd16755422;
      5: v = 34'sd8385879;
      6: v = 34'sd4193963;
      7: v = 34'sd2097109;
      8: v = 34'sd1048571;
      9: v = 34'sd524287;
      default: begin
        if (i <= 28) begin
          v = 34'sd1 <<< (28 - i);
        end else begin
          v = '0;
        end
      end
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/rve_sqrt.sv]
module rve_sqrt import rve_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] xs   [SQRT_LAT];
  logic [34:0] rems [SQRT_LAT];
  logic [31:0] qs   [SQRT_LAT];

  // One root bit per stage, restoring form.
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [63:0] x_in;
    logic [34:0] r_in;
    logic [31:0] q_in;
    logic [34:0] r_sh;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign x_in = radicand;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rems[k-1];
      assign q_in = qs[k-1];
    end

    assign r_sh  = {r_in[32:0], x_in[63:62]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge    = (r_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k]   <= {x_in[61:0], 2'b00};
        rems[k] <= ge ? (r_sh - trial) : r_sh;
        qs[k]   <= {q_in[30:0], ge};
      end
    end
  end

  assign root = qs[SQRT_LAT-1];

endmodule

[hdl/rve_div_lane.sv]
module rve_div_lane import rve_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag,
  input  logic [31:0] divisor,
  output logic [30:0] quo
);

  logic [32:0] rems [CORE_LAT];
  logic [30:0] qs   [CORE_LAT];
  logic [31:0] ds   [CORE_LAT];

  // One quotient bit per stage; stages past the last bit only pass the result on.
  for (genvar j = 0; j < CORE_LAT; j++) begin : g_stage
    logic [32:0] r_in;
    logic [30:0] q_in;
    logic [31:0] d_in;
    logic [32:0] sh;
    logic        ge;

    if (j == 0) begin : g_first
      assign r_in = {1'b0, mag};
      assign q_in = '0;
      assign d_in = divisor;
      assign sh   = r_in;
    end else begin : g_next
      assign r_in = rems[j-1];
      assign q_in = qs[j-1];
      assign d_in = ds[j-1];
      assign sh   = {r_in[31:0], 1'b0};
    end

    assign ge = (sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        ds[j] <= d_in;
        if (j < DIV_STEPS) begin
          rems[j] <= ge ? (sh - {1'b0, d_in}) : sh;
          qs[j]   <= {q_in[29:0], ge};
        end else begin
          rems[j] <= r_in;
          qs[j]   <= q_in;
        end
      end
    end
  end

  assign quo = qs[CORE_LAT-1];

endmodule

[hdl/rve_cordic.sv]
module rve_cordic import rve_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] angle,
  output logic signed [CW-1:0] cos_x,
  output logic signed [CW-1:0] sin_y
);

  logic signed [CW-1:0] xs [CORE_LAT];
  logic signed [CW-1:0] ys [CORE_LAT];
  logic signed [CW-1:0] zs [CORE_LAT];

  // One micro-rotation per stage; spare stages at the end hold the values.
  for (genvar i = 0; i < CORE_LAT; i++) begin : g_stage
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = angle;
    end else begin : g_next
      assign x_in = xs[i-1];
      assign y_in = ys[i-1];
      assign z_in = zs[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (i >= TRIG_ITERATIONS) begin
          xs[i] <= x_in;
          ys[i] <= y_in;
          zs[i] <= z_in;
        end else if (!z_in[CW-1]) begin
          xs[i] <= x_in - dx;
          ys[i] <= y_in + dy;
          zs[i] <= z_in - atan_step(i);
        end else begin
          xs[i] <= x_in + dx;
          ys[i] <= y_in - dy;
          zs[i] <= z_in + atan_step(i);
        end
      end
    end
  end

  assign cos_x = xs[CORE_LAT-1];
  assign sin_y = ys[CORE_LAT-1];

endmodule

[hdl/rve_merge.sv]
module rve_merge import rve_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] cos_x,
  input  logic signed [CW-1:0] sin_y,
  input  logic                 neg_cos,
  input  logic signed [31:0]   k0,
  input  logic signed [31:0]   k1,
  input  logic signed [31:0]   k2,
  input  vec_t                 psi,
  input  logic                 low_angle,
  output mat_t                 mat
);

  // First stage: sine times axis, and axis outer products.
  logic signed [CW-1:0] cs;
  logic signed [CW-1:0] omc_a;
  logic signed [65:0]   sk0_a, sk1_a, sk2_a;
  logic signed [63:0]   p00_a, p11_a, p22_a, p01_a, p02_a, p12_a;
  vec_t                 psi_a;
  logic                 small_a;

  assign cs = neg_cos ? -cos_x : cos_x;

  always_ff @(posedge clk) begin
    if (en) begin
      omc_a   <= Q30_ONE - cs;
      sk0_a   <= 66'(sin_y) * 66'(k0);
      sk1_a   <= 66'(sin_y) * 66'(k1);
      sk2_a   <= 66'(sin_y) * 66'(k2);
      p00_a   <= 64'(k0) * 64'(k0);
      p11_a   <= 64'(k1) * 64'(k1);
      p22_a   <= 64'(k2) * 64'(k2);
      p01_a   <= 64'(k0) * 64'(k1);
      p02_a   <= 64'(k0) * 64'(k2);
      p12_a   <= 64'(k1) * 64'(k2);
      psi_a   <= psi;
      small_a <= low_angle;
    end
  end

  // Second stage: squared skew matrix and sine terms, scaled back to Q1.30.
  logic signed [64:0] d0_w, d1_w, d2_w;
  logic signed [63:0] o01_w, o02_w, o12_w;
  logic signed [65:0] n0_w, n1_w, n2_w;
  logic signed [34:0] k00_b, k11_b, k22_b, k01_b, k02_b, k12_b;
  logic signed [35:0] s01_b, s02_b, s10_b, s12_b, s20_b, s21_b;
  logic signed [CW-1:0] omc_b;
  vec_t               psi_b;
  logic               small_b;

  assign d0_w  = -65'(p22_a) - 65'(p11_a);
  assign d1_w  = -65'(p00_a) - 65'(p22_a);
  assign d2_w  = -65'(p00_a) - 65'(p11_a);
  assign o01_w = p01_a >>> 30;
  assign o02_w = p02_a >>> 30;
  assign o12_w = p12_a >>> 30;
  assign n0_w  = -sk0_a;
  assign n1_w  = -sk1_a;
  assign n2_w  = -sk2_a;

  always_ff @(posedge clk) begin
    if (en) begin
      k00_b   <= 35'(d0_w >>> 30);
      k11_b   <= 35'(d1_w >>> 30);
      k22_b   <= 35'(d2_w >>> 30);
      k01_b   <= 35'(o01_w);
      k02_b   <= 35'(o02_w);
      k12_b   <= 35'(o12_w);
      s01_b   <= 36'(n2_w >>> 30);
      s02_b   <= 36'(sk1_a >>> 30);
      s10_b   <= 36'(sk2_a >>> 30);
      s12_b   <= 36'(n0_w >>> 30);
      s20_b   <= 36'(n1_w >>> 30);
      s21_b   <= 36'(sk0_a >>> 30);
      omc_b   <= omc_a;
      psi_b   <= psi_a;
      small_b <= small_a;
    end
  end

  // Third stage: one-minus-cosine terms.
  logic signed [68:0] c00_w, c11_w, c22_w, c01_w, c02_w, c12_w;
  logic signed [40:0] c00_c, c11_c, c22_c, c01_c, c02_c, c12_c;
  logic signed [40:0] s01_c, s02_c, s10_c, s12_c, s20_c, s21_c;
  vec_t               psi_c;
  logic               small_c;

  assign c00_w = 69'(omc_b) * 69'(k00_b);
  assign c11_w = 69'(omc_b) * 69'(k11_b);
  assign c22_w = 69'(omc_b) * 69'(k22_b);
  assign c01_w = 69'(omc_b) * 69'(k01_b);
  assign c02_w = 69'(omc_b) * 69'(k02_b);
  assign c12_w = 69'(omc_b) * 69'(k12_b);

  always_ff @(posedge clk) begin
    if (en) begin
      c00_c   <= 41'(c00_w >>> 30);
      c11_c   <= 41'(c11_w >>> 30);
      c22_c   <= 41'(c22_w >>> 30);
      c01_c   <= 41'(c01_w >>> 30);
      c02_c   <= 41'(c02_w >>> 30);
      c12_c   <= 41'(c12_w >>> 30);
      s01_c   <= 41'(s01_b);
      s02_c   <= 41'(s02_b);
      s10_c   <= 41'(s10_b);
      s12_c   <= 41'(s12_b);
      s20_c   <= 41'(s20_b);
      s21_c   <= 41'(s21_b);
      psi_c   <= psi_b;
      small_c <= small_b;
    end
  end

  // Final sums, small-angle form and saturation.
  logic signed [40:0] px, py, pz;
  logic signed [40:0] one41;

  assign px    = 41'(psi_c.x);
  assign py    = 41'(psi_c.y);
  assign pz    = 41'(psi_c.z);
  assign one41 = 41'(Q30_ONE);

  always_comb begin
    if (small_c) begin
      mat.m00 = sat32(one41);
      mat.m01 = sat32(-(pz <<< 2));
      mat.m02 = sat32(py <<< 2);
      mat.m10 = sat32(pz <<< 2);
      mat.m11 = sat32(one41);
      mat.m12 = sat32(-(px <<< 2));
      mat.m20 = sat32(-(py <<< 2));
      mat.m21 = sat32(px <<< 2);
      mat.m22 = sat32(one41);
    end else begin
      mat.m00 = sat32(one41 + c00_c);
      mat.m01 = sat32(s01_c + c01_c);
      mat.m02 = sat32(s02_c + c02_c);
      mat.m10 = sat32(s10_c + c01_c);
      mat.m11 = sat32(one41 + c11_c);
      mat.m12 = sat32(s12_c + c12_c);
      mat.m20 = sat32(s20_c + c02_c);
      mat.m21 = sat32(s21_c + c12_c);
      mat.m22 = sat32(one41 + c22_c);
    end
  end

endmodule

[hdl/rotation_vector_exponential_unit.sv]
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     rot_x, rot_y, rot_z (Q3.28)
// output    out        out_valid / out_stall   m00 .. m22 (Q1.30)
// config    in         cfg_we                  cfg_wdata (small-angle threshold)
//
// One request is taken per cycle while in_stall is low.
// Requests pass the front, the 32-stage square root, the reduction, then the core in which three
// divider lanes (one quotient bit a stage) run beside the CORDIC, then a three-stage merge.
// Reset clears the pipeline valid bits and the output and skid valid flags, and sets the
// threshold to 16.
// An output stall freezes the pipeline only once the skid register is also full.
module rotation_vector_exponential_unit import rve_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22
);

  logic                en;
  logic                accept;
  logic                skid_valid;
  logic [PIPE_LAT-1:0] vld;
  logic [30:0]         thr;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 31'd16;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Valid bits travel with the requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  // Front: component squares, then their sum.
  logic [31:0] mag_x, mag_y, mag_z;
  logic [63:0] sq0, sq1, sq2;
  logic [63:0] sum;
  vec_t        psi1, psi2;

  assign mag_x = rot_x[31] ? 32'(-rot_x) : rot_x;
  assign mag_y = rot_y[31] ? 32'(-rot_y) : rot_y;
  assign mag_z = rot_z[31] ? 32'(-rot_z) : rot_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sq0  <= 64'(mag_x) * 64'(mag_x);
      sq1  <= 64'(mag_y) * 64'(mag_y);
      sq2  <= 64'(mag_z) * 64'(mag_z);
      psi1 <= '{x: rot_x, y: rot_y, z: rot_z};
      sum  <= sq0 + sq1 + sq2;
      psi2 <= psi1;
    end
  end

  // Angle from the integer square root.
  logic [31:0] theta;
  vec_t        psi_sq [SQRT_LAT];

  rve_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .root     (theta)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      psi_sq[0] <= psi2;
      for (int i = 1; i < SQRT_LAT; i++) begin
        psi_sq[i] <= psi_sq[i-1];
      end
    end
  end

  // Reduction, first step: remove whole turns.
  logic [31:0] rr1;
  logic [31:0] theta_r1;
  vec_t        psi_r1;
  logic        small_r1;

  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, theta} >= TWO_TURN_U) begin
        rr1 <= 32'({1'b0, theta} - TWO_TURN_U);
      end else if ({1'b0, theta} >= TURN_U) begin
        rr1 <= 32'({1'b0, theta} - TURN_U);
      end else begin
        rr1 <= theta;
      end
      theta_r1 <= theta;
      psi_r1   <= psi_sq[SQRT_LAT-1];
      small_r1 <= (theta == '0) || (theta < {1'b0, thr});
    end
  end

  // Reduction, second step: fold into the CORDIC range.
  logic signed [CW-1:0] r_w;
  logic signed [CW-1:0] z_w;
  logic                 neg_w;
  logic signed [CW-1:0] z_r2;
  logic [31:0]          theta_r2;
  logic [31:0]          mag_r2 [3];
  side_t                side_r2;

  always_comb begin
    r_w = $signed({2'b00, rr1});
    if (r_w > PI_Q28) begin
      r_w = r_w - TWO_PI_Q28;
    end
    z_w   = r_w;
    neg_w = 1'b0;
    if (r_w > HALF_PI_Q28) begin
      z_w   = PI_Q28 - r_w;
      neg_w = 1'b1;
    end else if (r_w < -HALF_PI_Q28) begin
      z_w   = -PI_Q28 - r_w;
      neg_w = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r2      <= z_w;
      theta_r2  <= theta_r1;
      mag_r2[0] <= psi_r1.x[31] ? 32'(-psi_r1.x) : psi_r1.x;
      mag_r2[1] <= psi_r1.y[31] ? 32'(-psi_r1.y) : psi_r1.y;
      mag_r2[2] <= psi_r1.z[31] ? 32'(-psi_r1.z) : psi_r1.z;
      side_r2   <= '{low_angle: small_r1, neg_cos: neg_w, psi: psi_r1};
    end
  end

  // Core: one divider lane per axis component, beside the CORDIC.
  logic [30:0]          quo [3];
  logic signed [CW-1:0] cos_x;
  logic signed [CW-1:0] sin_y;
  side_t                side_core [CORE_LAT];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rve_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .mag     (mag_r2[l]),
      .divisor (theta_r2),
      .quo     (quo[l])
    );
  end

  rve_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .angle (z_r2),
    .cos_x (cos_x),
    .sin_y (sin_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_core[0] <= side_r2;
      for (int i = 1; i < CORE_LAT; i++) begin
        side_core[i] <= side_core[i-1];
      end
    end
  end

  // Signed unit axis.
  side_t              side_m;
  logic signed [31:0] kq [3];

  assign side_m = side_core[CORE_LAT-1];
  assign kq[0]  = side_m.psi.x[31] ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
  assign kq[1]  = side_m.psi.y[31] ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
  assign kq[2]  = side_m.psi.z[31] ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});

  // Merge the lanes into the matrix.
  mat_t mat;

  rve_merge u_merge (
    .clk       (clk),
    .en        (en),
    .cos_x     (cos_x),
    .sin_y     (sin_y),
    .neg_cos   (side_m.neg_cos),
    .k0        (kq[0]),
    .k1        (kq[1]),
    .k2        (kq[2]),
    .psi       (side_m.psi),
    .low_angle (side_m.low_angle),
    .mat       (mat)
  );

  // Output register with a skid register behind it.
  logic push;
  mat_t out_m;
  mat_t skid_m;

  assign push = en && vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_m <= skid_m;
      end else if (push) begin
        out_m <= mat;
      end
    end else if (push) begin
      skid_m <= mat;
    end
  end

  assign m00 = out_m.m00;
  assign m01 = out_m.m01;
  assign m02 = out_m.m02;
  assign m10 = out_m.m10;
  assign m11 = out_m.m11;
  assign m12 = out_m.m12;
  assign m20 = out_m.m20;
  assign m21 = out_m.m21;
  assign m22 = out_m.m22;

  // The skid register is only in use behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register occupied with empty output register");

  // The skid register fills only when the output is held.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled while output was free");

  // A released skid entry moves into the output register.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> out_valid && !skid_valid)
    else $error("skid entry not moved to output");

endmodule

[dv/rotation_vector_exponential_unit_tb.sv]
`timescale 1ns / 100ps

module rotation_vector_exponential_unit_tb;
  import rve_pkg::*;

  localparam int LATENCY = PIPE_LAT;

  // Expected rotation matrix for one request.
  typedef struct {
    logic signed [31:0] e[9];
  } matrix_exp_t;

  // Fixed-point Rodrigues predictor and the queue of matrices still owed.
  class rotation_scoreboard;
    logic [30:0] threshold;
    matrix_exp_t pending[$];
    int mismatches;

    function new();
      threshold = 31'd16;
      mismatches = 0;
    endfunction

    // Arithmetic shift right with floor rounding.
    function automatic longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) begin
        b = b >> 2;
      end
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function automatic longint arctan_q28(int i);
      longint head[10];
      head = '{210828714, 124459457, 65760959, 33381290, 16755422,
               8385879, 4193963, 2097109, 1048571, 524287};
      if (i < 10) begin
        return head[i];
      end
      if (i <= 28) begin
        return 64'sd1 << (28 - i);
      end
      return 0;
    endfunction

    // Work out the matrix for one accepted request.
    function void note_request(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
      longint p[3];
      longint k[3];
      longint sk[9];
      longint k2[9];
      longint unsigned sum;
      longint unsigned th;
      longint unsigned a;
      longint rr, x, y, z, dx, dy, cs, sn, omc;
      bit neg_cos;
      matrix_exp_t m;
      p[0] = longint'(px);
      p[1] = longint'(py);
      p[2] = longint'(pz);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        a = (p[i] < 0) ? -p[i] : p[i];
        sum = sum + a * a;
      end
      th = root64(sum);
      if (th == 0 || th < threshold) begin
        sk = '{0, -p[2], p[1], p[2], 0, -p[0], -p[1], p[0], 0};
        for (int j = 0; j < 9; j++) begin
          m.e[j] = 32'(clamp32(((j % 4 == 0) ? 64'sd1073741824 : 0) + sk[j] * 4));
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          a = (p[i] < 0) ? -p[i] : p[i];
          k[i] = longint'((a << 30) / th);
          if (p[i] < 0) begin
            k[i] = -k[i];
          end
        end
        // Fold the angle into [-pi/2, pi/2].
        neg_cos = 0;
        rr = longint'(th);
        while (rr >= 2 * 843314857) begin
          rr = rr - 2 * 843314857;
        end
        if (rr > 843314857) begin
          rr = rr - 2 * 843314857;
        end
        if (rr > 421657428) begin
          rr = 843314857 - rr;
          neg_cos = 1;
        end else if (rr < -421657428) begin
          rr = -843314857 - rr;
          neg_cos = 1;
        end
        // CORDIC rotation.
        x = 652032874;
        y = 0;
        z = rr;
        for (int i = 0; i < TRIG_ITERATIONS; i++) begin
          dx = shr(y, i);
          dy = shr(x, i);
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_q28(i);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_q28(i);
          end
        end
        cs = neg_cos ? -x : x;
        sn = y;
        omc = 64'sd1073741824 - cs;
        sk = '{0, -k[2], k[1], k[2], 0, -k[0], -k[1], k[0], 0};
        k2[0] = -(k[2] * k[2]) - k[1] * k[1];
        k2[4] = -(k[0] * k[0]) - k[2] * k[2];
        k2[8] = -(k[0] * k[0]) - k[1] * k[1];
        k2[1] = k[0] * k[1];
        k2[3] = k2[1];
        k2[2] = k[0] * k[2];
        k2[6] = k2[2];
        k2[5] = k[1] * k[2];
        k2[7] = k2[5];
        for (int j = 0; j < 9; j++) begin
          m.e[j] = 32'(clamp32(((j % 4 == 0) ? 64'sd1073741824 : 0)
                               + shr(sn * sk[j], 30) + shr(omc * shr(k2[j], 30), 30)));
        end
      end
      pending.push_back(m);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic signed [31:0] got[9]);
      matrix_exp_t m;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      m = pending.pop_front();
      for (int j = 0; j < 9; j++) begin
        if (got[j] !== m.e[j]) begin
          report_mismatch($sformatf("m%0d%0d got %0d expected %0d",
                                    j / 3, j % 3, got[j], m.e[j]));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic cfg_we;
  logic [30:0] cfg_wdata;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  rotation_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  rotation_vector_exponential_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: random stall, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    logic signed [31:0] got[9];
    if (!rst && out_valid && !out_stall) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      sb.check_result(got);
    end
  end

  // Offer one request and hold it until it is taken.
  task automatic send_request(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rot_x <= x;
    rot_y <= y;
    rot_z <= z;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_request(x, y, z);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = v;
  endtask

  // Random vector: mostly moderate angles, some full-range, some tiny.
  task automatic send_random();
    logic signed [31:0] v[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) begin
        v[i] = $signed($urandom_range(32'h7fffffff)) >>> $urandom_range(8, 1);
        if ($urandom_range(1)) begin
          v[i] = -v[i];
        end
      end else if (kind < 8) begin
        v[i] = $urandom;
      end else begin
        v[i] = $signed($urandom) >>> $urandom_range(31, 20);
      end
    end
    send_request(v[0], v[1], v[2]);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rot_x = '0;
    rot_y = '0;
    rot_z = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, axes, extremes, angle folding regions, tiny vectors.
    send_request(0, 0, 0);
    send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_request(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_request(32'sh80000000, 0, 0);
    send_request(0, 32'sh7fffffff, 0);
    send_request(0, 0, 32'sh80000000);
    send_request(32'sd268435456, 0, 0);
    send_request(0, -32'sd421657428, 0);
    send_request(0, 0, 32'sd843314857);
    send_request(32'sd843314858, 0, 0);
    send_request(32'sd1686629714, 0, 0);
    send_request(-32'sd600000000, 32'sd600000000, 32'sd600000000);
    send_request(5, -7, 3);
    send_request(15, 0, 0);
    send_request(16, 0, 0);
    send_request(-1, 1, -1);
    drain();
    write_threshold(31'd0);
    send_request(0, 0, 0);
    send_request(1, 0, 0);
    send_request(32'sh80000000, 32'sh7fffffff, 1);
    drain();
    write_threshold(31'h7fffffff);
    send_request(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_request(32'sh40000000, -32'sh40000000, 32'sh20000000);
    drain();
    write_threshold(31'd16);

    // Random phases with different input idling and output stalling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 74 : ((ph == 2) ? 7 : 0);
      stall_pct = (ph == 3) ? 74 : ((ph == 2) ? 7 : 0);
      if (ph == 0) begin
        hold_cycles = 3 * LATENCY;
      end
      for (int n = 0; n < 300; n++) begin
        send_random();
      end
      drain();
      case (ph)
        0: write_threshold(31'($urandom_range(31'h0fffffff)));
        1: write_threshold(31'd0);
        2: write_threshold(31'h7fffffff);
        default: write_threshold(31'd1000);
      endcase
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
